FILE: design/round_robin_delay_scheduler_defines.svh
// Assertion macros used by the round-robin delay scheduler top level.
`ifndef ROUND_ROBIN_DELAY_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_DELAY_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define RRDS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");
// Antecedent implies consequent in the following cycle.
`define RRDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define RRDS_ASSERT_NOW(label, clk, rst, ante, cons)
`define RRDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/rrds_pkg.sv
// Package with types and constants of the round-robin delay scheduler.
package rrds_pkg;

  localparam int TASK_COUNT_DEF = 8;

  // Command kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_DELAY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] delay_ticks;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  running_task;
    logic        idle;
    logic [15:0] tick_count;
  } rsp_t;

  // Controls that move the ring of skip counters.
  typedef struct packed {
    logic shift;
    logic write;
  } ring_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

FILE: design/round_robin_delay_scheduler.sv
// Top level of the round-robin task scheduler with per-task tick delays.
//
// Usage: a command beat (cmd.kind, cmd.delay_ticks) is taken at a rising
// edge with start high and busy low. A delay command loads the running
// task's skip counter (dropped while the idle task runs); a tick command
// advances the tick count and walks the task ring to the next ready task.
// Every command gives one result beat on rsp, marked by done for exactly
// one cycle; the receiver cannot stall, so rsp must be taken when done is
// high.
// A delay command answers in the cycle after it is taken and leaves
// busy low, so commands may follow back to back. A tick command rotates the
// ring of skip-counter cells by one position a cycle, holding busy high;
// it passes each delayed task it meets, at most TASK_COUNT of them, before
// it answers with the next ready task, or reports idle when all were passed.
// The ring rotation through the cell chain sets how long a tick takes.
// Reset clears all skip counters, the tick count and the idle flag and
// points the ring at the last task; the first command may follow at once.
`include "round_robin_delay_scheduler_defines.svh"

module round_robin_delay_scheduler #(
  parameter int TASK_COUNT = rrds_pkg::TASK_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rrds_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done,
  output rrds_pkg::rsp_t rsp
);

  rrds_pkg::ring_ctl_t ring_ctl;
  rrds_pkg::ring_ctl_t cell_ctl [TASK_COUNT];
  logic [15:0]         cell_value [TASK_COUNT];
  logic [15:0]         head_dec;
  logic                head_nonzero;
  logic                take_tick;
  logic                take_delay;

  // The head cell always holds the counter of the task at the ring position.
  assign head_nonzero = (cell_value[0] != 16'd0);
  assign head_dec     = head_nonzero ? cell_value[0] - 16'd1 : 16'd0;

  // Command beats taken in this cycle, by kind.
  assign take_tick  = start && !busy && (cmd.kind == rrds_pkg::KIND_TICK);
  assign take_delay = start && !busy && (cmd.kind == rrds_pkg::KIND_DELAY);

  rrds_ctrl #(
    .TASK_COUNT(TASK_COUNT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .head_nonzero(head_nonzero),
    .busy        (busy),
    .ring_ctl    (ring_ctl),
    .done        (done),
    .rsp         (rsp)
  );

  // Chain of cells; the head counter, counted down, wraps round to the tail.
  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    logic [15:0] shift_in;
    if (i == TASK_COUNT - 1) begin : g_tail
      assign shift_in = head_dec;
    end else begin : g_mid
      assign shift_in = cell_value[i+1];
    end
    if (i == 0) begin : g_head
      assign cell_ctl[i] = ring_ctl;
    end else begin : g_body
      assign cell_ctl[i] = '{shift: ring_ctl.shift, write: 1'b0};
    end
    rrds_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl[i]),
      .write_data(cmd.delay_ticks),
      .shift_in  (shift_in),
      .value     (cell_value[i])
    );
  end

  // A result beat only comes out when the sequencer is free again.
  `RRDS_ASSERT_NOW(a_done_not_busy, clk, rst, done, !busy)
  // A taken tick keeps the block busy in the next cycle with no result yet.
  `RRDS_ASSERT_NEXT(a_tick_walks, clk, rst, take_tick, busy && !done)
  // A taken delay answers in the next cycle.
  `RRDS_ASSERT_NEXT(a_delay_answers, clk, rst, take_delay, done)
  // The ring never shifts and loads in the same cycle.
  `RRDS_ASSERT_NOW(a_ring_ctl_excl, clk, rst, ring_ctl.write, !ring_ctl.shift && !busy)

endmodule

FILE: design/rrds_cell.sv
// One ring cell holding a task skip counter.
module rrds_cell (
  input  logic                clk,
  input  logic                rst,
  input  rrds_pkg::ring_ctl_t ctl,
  input  logic [15:0]         write_data,
  input  logic [15:0]         shift_in,
  output logic [15:0]         value
);

  // A write loads the running task's counter; a shift takes the neighbor's value.
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= 16'd0;
    end else if (ctl.write) begin
      value <= write_data;
    end else if (ctl.shift) begin
      value <= shift_in;
    end
  end

endmodule

FILE: design/rrds_ctrl.sv
// Sequencer of the scheduler: command handling, ring walk and result beat.
module rrds_ctrl #(
  parameter int TASK_COUNT = rrds_pkg::TASK_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rrds_pkg::cmd_t      cmd,
  input  logic                head_nonzero,
  output logic                busy,
  output rrds_pkg::ring_ctl_t ring_ctl,
  output logic                done,
  output rrds_pkg::rsp_t      rsp
);

  localparam int IDX_W  = $clog2(TASK_COUNT);
  localparam int PASS_W = $clog2(TASK_COUNT + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TASK_COUNT - 1);
  localparam logic [PASS_W-1:0] ALL_PASS  = PASS_W'(TASK_COUNT);

  rrds_pkg::state_t state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [PASS_W-1:0] passed, passed_next;
  logic              idle_running, idle_running_next;
  logic [15:0]       ticks, ticks_next;
  logic              done_next;
  rrds_pkg::rsp_t    rsp_next;
  logic [IDX_W-1:0]  idx_step;
  logic [IDX_W+2:0]  idx_ext;

  // Next ring position and the low three bits reported as the running task.
  assign idx_step = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign idx_ext  = {3'b000, idx};
  assign busy     = (state != rrds_pkg::ST_IDLE);

  // State register and result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rrds_pkg::ST_IDLE;
      idx          <= LAST_IDX;
      idle_running <= 1'b0;
      ticks        <= 16'd0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      idx          <= idx_next;
      idle_running <= idle_running_next;
      ticks        <= ticks_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    passed <= passed_next;
    rsp    <= rsp_next;
  end

  // Next state: a delay finishes at once, a tick rotates the ring until a
  // ready task reaches the head or every task has been passed once.
  always_comb begin
    state_next        = state;
    idx_next          = idx;
    passed_next       = passed;
    idle_running_next = idle_running;
    ticks_next        = ticks;
    done_next         = 1'b0;
    rsp_next          = rsp;
    ring_ctl          = '{shift: 1'b0, write: 1'b0};
    unique case (state)
      rrds_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd.kind == rrds_pkg::KIND_DELAY) begin
            ring_ctl.write = !idle_running;
            done_next      = 1'b1;
            rsp_next       = '{running_task: idx_ext[2:0], idle: idle_running,
                               tick_count: ticks};
          end else begin
            ring_ctl.shift = 1'b1;
            ticks_next     = ticks + 16'd1;
            idx_next       = idx_step;
            passed_next    = '0;
            state_next     = rrds_pkg::ST_WALK;
          end
        end
      end
      rrds_pkg::ST_WALK: begin
        if (head_nonzero && (passed != ALL_PASS)) begin
          ring_ctl.shift = 1'b1;
          idx_next       = idx_step;
          passed_next    = passed + 1'b1;
        end else begin
          idle_running_next = (passed == ALL_PASS);
          done_next         = 1'b1;
          rsp_next          = '{running_task: idx_ext[2:0], idle: (passed == ALL_PASS),
                                tick_count: ticks};
          state_next        = rrds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rrds_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
